FILE: hdl/cstp_pkg.sv
// shared types and codes for the call-stack exclusive-time profiler
package cstp_pkg;

	localparam int unsigned ID_W    = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned AMT_W   = 33;
	localparam int unsigned TOTAL_W = 40;

	// event actions
	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_END   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NONE     = 3'd1;
	localparam logic [2:0] ST_OVER     = 3'd2;
	localparam logic [2:0] ST_UNDER    = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;
	localparam logic [2:0] ST_BACK     = 3'd5;

	typedef struct packed {
		logic [1:0]        action;
		logic [ID_W-1:0]   func_id;
		logic [TIME_W-1:0] timestamp;
	} event_t;

	typedef struct packed {
		logic [ID_W-1:0]    charged_id;
		logic [AMT_W-1:0]   charged_amount;
		logic [TOTAL_W-1:0] running_total;
		logic [2:0]         status;
	} result_t;

endpackage

FILE: hdl/cstp_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module cstp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/call_stack_exclusive_time_profiler_core.sv
// call-stack exclusive-time profiler: stack tracking, charge and saturating totals
//
//   channel  | signals                       | word type          | direction
//   ---------+-------------------------------+--------------------+----------
//   event    | event_valid/ready/word        | cstp_pkg::event_t  | in
//   result   | result_valid/ready/word       | cstp_pkg::result_t | out
//
// one event word per cycle sustained while result_ready takes each result word; each result word is registered through
// three stages: input register (stack update), totals ram read stage, result register
// the totals ram read-modify-write is one pass per event, forwarded back-to-back
// arst_n clears the stack count, resume time, total valid bits and all stage valids
// a stalled result holds the pipe back only as far as the empty stages allow
module call_stack_exclusive_time_profiler_core #(
	parameter int unsigned NUM_FUNCTIONS = 256,
	parameter int unsigned STACK_DEPTH   = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              event_valid,
	output logic              event_ready,
	input  cstp_pkg::event_t  event_word,
	output logic              result_valid,
	input  logic              result_ready,
	output cstp_pkg::result_t result_word
);

	// ids are 8 bits, so no more than 256 totals ever exist
	localparam int unsigned TOT_DEPTH = (NUM_FUNCTIONS < 256) ? NUM_FUNCTIONS : 256;
	localparam int unsigned TAW = (TOT_DEPTH > 1) ? $clog2(TOT_DEPTH) : 1;
	localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);

	localparam int unsigned IDW = cstp_pkg::ID_W;
	localparam int unsigned AMW = cstp_pkg::AMT_W;
	localparam int unsigned TW  = cstp_pkg::TOTAL_W;

	// what the stack stage hands to the totals stage
	typedef struct packed {
		logic [IDW-1:0] cid;
		logic [AMW-1:0] amount;
		logic [2:0]     status;
		logic           charge;
		logic           in_range;
		logic [TAW-1:0] addr;
		logic           fwd_hit;
		logic [TW-1:0]  fwd_data;
	} stage2_t;

	// pipeline handshake
	logic             vld_s1, vld_s2, result_valid_q;
	logic             s1_move, s2_move, out_free, s2_free;
	cstp_pkg::event_t ev_s1;
	stage2_t          st_s2;
	cstp_pkg::result_t result_q;

	// stack state: top kept in a register, entries below it in ram
	logic [CW-1:0]    count_q, count_nxt;
	logic [IDW-1:0]   top_q;
	logic [AMW-1:0]   resume_q;
	logic             byp_q;
	logic [IDW-1:0]   byp_data_q;
	logic [IDW-1:0]   stk_rdata, below;
	logic             stk_we;
	logic [SAW-1:0]   stk_waddr, stk_raddr;

	// stack stage decisions
	logic [AMW-1:0]   t_ev, t_end;
	logic [IDW-1:0]   cid;
	logic [AMW-1:0]   amount;
	logic [2:0]       status;
	logic             charge, push, pop, cid_in_range;

	// totals stage
	logic [TOT_DEPTH-1:0] tv_q;
	logic [TW-1:0]        tot_rdata, old_total, sum_sat, total;
	logic [TW:0]          sum_full;
	logic                 tot_we;

	assign out_free    = !result_valid_q || result_ready;
	assign s2_move     = vld_s2 && out_free;
	assign s2_free     = !vld_s2 || s2_move;
	assign s1_move     = vld_s1 && s2_free;
	assign event_ready = !vld_s1 || s1_move;

	assign result_valid = result_valid_q;
	assign result_word  = result_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (event_ready) begin
			vld_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_valid && event_ready) begin
			ev_s1 <= event_word;
		end
	end

	// entry just under the top: ram data, or the word written into that slot last cycle
	assign below = byp_q ? byp_data_q : stk_rdata;

	// event decode against the stack
	always_comb begin
		t_ev   = {1'b0, ev_s1.timestamp};
		t_end  = t_ev + AMW'(1);
		cid    = ev_s1.func_id;
		amount = '0;
		status = cstp_pkg::ST_OK;
		charge = 1'b0;
		push   = 1'b0;
		pop    = 1'b0;
		case (ev_s1.action)
			cstp_pkg::ACT_START: begin
				if (t_ev < resume_q) begin
					status = cstp_pkg::ST_BACK;
				end else if (count_q == CW'(STACK_DEPTH)) begin
					status = cstp_pkg::ST_OVER;
				end else begin
					push = 1'b1;
					if (count_q == '0) begin
						// nothing running yet, so nobody to charge
						status = cstp_pkg::ST_NONE;
					end else begin
						cid    = top_q;
						amount = t_ev - resume_q;
						charge = 1'b1;
					end
				end
			end
			cstp_pkg::ACT_END: begin
				if (count_q == '0) begin
					status = cstp_pkg::ST_UNDER;
				end else if (top_q != ev_s1.func_id) begin
					status = cstp_pkg::ST_MISMATCH;
				end else if (t_end < resume_q) begin
					status = cstp_pkg::ST_BACK;
				end else begin
					pop    = 1'b1;
					charge = 1'b1;
					amount = t_end - resume_q;
				end
			end
			cstp_pkg::ACT_READ: begin
				status = cstp_pkg::ST_OK;
			end
			default: begin
				status = cstp_pkg::ST_NONE;
			end
		endcase
	end

	assign cid_in_range = 32'(cid) < NUM_FUNCTIONS;

	always_comb begin
		count_nxt = count_q;
		if (s1_move && push) begin
			count_nxt = count_q + CW'(1);
		end else if (s1_move && pop) begin
			count_nxt = count_q - CW'(1);
		end
	end

	// old top spills into ram on a push; ram keeps the under-top entry prefetched
	assign stk_we    = s1_move && push && (count_q != '0);
	assign stk_waddr = SAW'(count_q - CW'(1));
	assign stk_raddr = SAW'(count_nxt - CW'(2));

	cstp_ram #(
		.WIDTH (IDW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (top_q),
		.re    (1'b1),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			resume_q <= '0;
			byp_q    <= 1'b0;
		end else begin
			count_q <= count_nxt;
			byp_q   <= stk_we && (stk_waddr == stk_raddr);
			if (s1_move && push) begin
				resume_q <= t_ev;
			end else if (s1_move && pop) begin
				resume_q <= t_end;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_data_q <= top_q;
		if (s1_move && push) begin
			top_q <= ev_s1.func_id;
		end else if (s1_move && pop) begin
			top_q <= below;
		end
	end

	// totals: read issued as the event enters stage 2, written as it leaves
	cstp_ram #(
		.WIDTH (TW),
		.DEPTH (TOT_DEPTH)
	) u_totals_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (st_s2.addr),
		.wdata (sum_sat),
		.re    (s1_move),
		.raddr (TAW'(cid)),
		.rdata (tot_rdata)
	);

	// a write on the same edge as the read is not seen by the ram, so forward it
	always_comb begin
		if (st_s2.fwd_hit) begin
			old_total = st_s2.fwd_data;
		end else if (tv_q[st_s2.addr]) begin
			old_total = tot_rdata;
		end else begin
			old_total = '0;
		end
		sum_full = {1'b0, old_total} + (TW + 1)'(st_s2.amount);
		sum_sat  = sum_full[TW] ? '1 : sum_full[TW-1:0];
		if (!st_s2.in_range) begin
			total = '0;
		end else if (st_s2.charge) begin
			total = sum_sat;
		end else begin
			total = old_total;
		end
	end

	assign tot_we = s2_move && st_s2.charge && st_s2.in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			tv_q   <= '0;
		end else begin
			if (s2_free) begin
				vld_s2 <= vld_s1;
			end
			if (tot_we) begin
				tv_q[st_s2.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			st_s2.cid      <= cid;
			st_s2.amount   <= amount;
			st_s2.status   <= status;
			st_s2.charge   <= charge;
			st_s2.in_range <= cid_in_range;
			st_s2.addr     <= TAW'(cid);
			st_s2.fwd_hit  <= tot_we && (st_s2.addr == TAW'(cid));
			st_s2.fwd_data <= sum_sat;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			result_q.charged_id     <= st_s2.cid;
			result_q.charged_amount <= st_s2.amount;
			result_q.running_total  <= total;
			result_q.status         <= st_s2.status;
		end
	end

endmodule

FILE: hdl/cstp_checker.sv
// port-level checks for the profiler core, bound to the core module
module cstp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              event_ready,
	input logic              result_valid,
	input logic              result_ready,
	input cstp_pkg::result_t result_word
);

	// no result word is offered in the cycle after reset is seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !result_valid)
		else $error("result valid after reset");

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_word))
		else $error("stalled result word changed");

	// with no result word waiting the pipe always takes an event word
	a_event_free: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> event_ready)
		else $error("event stalled with an empty output");

	// status is always one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_word.status == cstp_pkg::ST_OK ||
			result_word.status == cstp_pkg::ST_NONE ||
			result_word.status == cstp_pkg::ST_OVER ||
			result_word.status == cstp_pkg::ST_UNDER ||
			result_word.status == cstp_pkg::ST_MISMATCH ||
			result_word.status == cstp_pkg::ST_BACK))
		else $error("undefined status code");

	// only a result word with status ok may carry a nonzero amount
	a_amount_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status != cstp_pkg::ST_OK
		|-> result_word.charged_amount == '0)
		else $error("amount charged on a failed or ignored event");

endmodule

bind call_stack_exclusive_time_profiler_core cstp_checker u_cstp_checker (.*);
